@@ rtl/ppu_pkg.sv @@
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types, constants and helper functions for the packed pixel unpacker.
// ----------------------------------------------------------------------------
package ppu_pkg;

    // Default number of stream bytes one pixel word can hold
    localparam int MAX_PIXEL_BYTES_DEF = 4;

    // Depth of the pixel queue between assembly and unpack
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration port geometry
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int REG_IW   = 3;

    // Register field widths
    localparam int BPP_W  = 3;
    localparam int OFF_W  = 5;
    localparam int SIZE_W = 4;

    // Reset values of the registers
    localparam logic [BPP_W-1:0]  BPP_RST   = 3'd2;
    localparam logic [OFF_W-1:0]  ROFF_RST  = 5'd11;
    localparam logic [SIZE_W-1:0] RSIZE_RST = 4'd5;
    localparam logic [OFF_W-1:0]  GOFF_RST  = 5'd5;
    localparam logic [SIZE_W-1:0] GSIZE_RST = 4'd6;
    localparam logic [OFF_W-1:0]  BOFF_RST  = 5'd0;
    localparam logic [SIZE_W-1:0] BSIZE_RST = 4'd5;

    // Register indexes on the configuration port
    typedef enum logic [REG_IW-1:0] {
        REG_BPP   = 3'd0,
        REG_ROFF  = 3'd1,
        REG_RSIZE = 3'd2,
        REG_GOFF  = 3'd3,
        REG_GSIZE = 3'd4,
        REG_BOFF  = 3'd5,
        REG_BSIZE = 3'd6
    } t_reg_idx;

    // Current configuration as seen by the datapath
    typedef struct packed {
        logic [BPP_W-1:0]  bpp;
        logic [OFF_W-1:0]  roff;
        logic [SIZE_W-1:0] rsize;
        logic [OFF_W-1:0]  goff;
        logic [SIZE_W-1:0] gsize;
        logic [OFF_W-1:0]  boff;
        logic [SIZE_W-1:0] bsize;
    } t_cfg;

    // Widen a field of the given size to eight bits by repeating its bits,
    // top bits first. Size zero gives 0, sizes above eight act as eight.
    function automatic logic [7:0] expand_field(input logic [7:0] f,
                                                input logic [SIZE_W-1:0] size);
        logic [7:0] r;
        case (size)
            4'd0:    r = 8'h00;
            4'd1:    r = {8{f[0]}};
            4'd2:    r = {4{f[1:0]}};
            4'd3:    r = {f[2:0], f[2:0], f[2:1]};
            4'd4:    r = {2{f[3:0]}};
            4'd5:    r = {f[4:0], f[4:2]};
            4'd6:    r = {f[5:0], f[5:4]};
            4'd7:    r = {f[6:0], f[6]};
            default: r = f;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/packed_pixel_unpacker.sv @@
// ----------------------------------------------------------------------------
// packed_pixel_unpacker
// Unpacks a little-endian framebuffer byte stream of 1..MAX_PIXEL_BYTES bytes
// per pixel into RGB888 using configurable bit fields for red, green and blue.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     i_valid / o_ready       i_data_byte, i_frame_start
//  output    o_valid / i_ready       o_red_out, o_green_out, o_blue_out
//  config    psel/penable/pwrite     paddr, pwdata, prdata, pready
//
//  One byte is taken per cycle while o_ready is high; the byte that completes
//  a pixel enters the queue at its accepting edge, then the output register.
//  A two-entry pixel queue sits between byte assembly and unpack, so input
//  keeps flowing while a result waits; o_ready drops only with the queue full.
//  Synchronous active-low reset clears the byte position, queue and output valid.
// ----------------------------------------------------------------------------
module packed_pixel_unpacker #(
    parameter int MAX_PIXEL_BYTES = ppu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ppu_pkg::APB_AW-1:0] paddr,
    input  logic [ppu_pkg::APB_DW-1:0] pwdata,
    output logic [ppu_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_frame_start,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_red_out,
    output logic [7:0]                 o_green_out,
    output logic [7:0]                 o_blue_out
);

    localparam int WORD_W = 8 * MAX_PIXEL_BYTES;

    ppu_pkg::t_cfg     cfg;
    logic              push;
    logic [WORD_W-1:0] push_word;
    logic              push_ready;
    logic              pop_valid;
    logic [WORD_W-1:0] pop_word;
    logic              pop;

    // Configuration registers
    ppu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Byte assembly
    ppu_front #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_push        (push),
        .o_push_word   (push_word),
        .i_push_ready  (push_ready)
    );

    // Pixel queue
    ppu_queue #(
        .WIDTH (WORD_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_word),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_word),
        .i_pop        (pop)
    );

    // Field unpack and output register
    ppu_back #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_word),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

endmodule

@@ rtl/ppu_regs.sv @@
// ----------------------------------------------------------------------------
// ppu_regs
// APB-style configuration registers: format of the pixel word and fields.
// ----------------------------------------------------------------------------
module ppu_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppu_pkg::APB_AW-1:0]   paddr,
    input  logic [ppu_pkg::APB_DW-1:0]   pwdata,
    output logic [ppu_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output ppu_pkg::t_cfg                o_cfg
);

    ppu_pkg::t_cfg              r_cfg;
    logic                       wr_en;
    logic [ppu_pkg::REG_IW-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ppu_pkg::APB_AW-1:2];
    assign o_cfg   = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpp   <= ppu_pkg::BPP_RST;
            r_cfg.roff  <= ppu_pkg::ROFF_RST;
            r_cfg.rsize <= ppu_pkg::RSIZE_RST;
            r_cfg.goff  <= ppu_pkg::GOFF_RST;
            r_cfg.gsize <= ppu_pkg::GSIZE_RST;
            r_cfg.boff  <= ppu_pkg::BOFF_RST;
            r_cfg.bsize <= ppu_pkg::BSIZE_RST;
        end else if (wr_en) begin
            case (ppu_pkg::t_reg_idx'(reg_idx))
                ppu_pkg::REG_BPP:   r_cfg.bpp   <= pwdata[ppu_pkg::BPP_W-1:0];
                ppu_pkg::REG_ROFF:  r_cfg.roff  <= pwdata[ppu_pkg::OFF_W-1:0];
                ppu_pkg::REG_RSIZE: r_cfg.rsize <= pwdata[ppu_pkg::SIZE_W-1:0];
                ppu_pkg::REG_GOFF:  r_cfg.goff  <= pwdata[ppu_pkg::OFF_W-1:0];
                ppu_pkg::REG_GSIZE: r_cfg.gsize <= pwdata[ppu_pkg::SIZE_W-1:0];
                ppu_pkg::REG_BOFF:  r_cfg.boff  <= pwdata[ppu_pkg::OFF_W-1:0];
                ppu_pkg::REG_BSIZE: r_cfg.bsize <= pwdata[ppu_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (ppu_pkg::t_reg_idx'(reg_idx))
            ppu_pkg::REG_BPP:   prdata = ppu_pkg::APB_DW'(r_cfg.bpp);
            ppu_pkg::REG_ROFF:  prdata = ppu_pkg::APB_DW'(r_cfg.roff);
            ppu_pkg::REG_RSIZE: prdata = ppu_pkg::APB_DW'(r_cfg.rsize);
            ppu_pkg::REG_GOFF:  prdata = ppu_pkg::APB_DW'(r_cfg.goff);
            ppu_pkg::REG_GSIZE: prdata = ppu_pkg::APB_DW'(r_cfg.gsize);
            ppu_pkg::REG_BOFF:  prdata = ppu_pkg::APB_DW'(r_cfg.boff);
            ppu_pkg::REG_BSIZE: prdata = ppu_pkg::APB_DW'(r_cfg.bsize);
            default:            prdata = '0;
        endcase
    end

endmodule

@@ rtl/ppu_front.sv @@
// ----------------------------------------------------------------------------
// ppu_front
// Byte assembler: gathers stream bytes little-endian into a pixel word and
// pushes each completed, masked word into the pixel queue.
// ----------------------------------------------------------------------------
module ppu_front #(
    parameter int MAX_PIXEL_BYTES = ppu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppu_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_frame_start,
    output logic                         o_push,
    output logic [8*MAX_PIXEL_BYTES-1:0] o_push_word,
    input  logic                         i_push_ready
);

    localparam int WORD_W    = 8 * MAX_PIXEL_BYTES;
    localparam int PARTIAL_W = 8 * (MAX_PIXEL_BYTES - 1);
    localparam int PW        = $clog2(MAX_PIXEL_BYTES);
    localparam int BW        = $clog2(MAX_PIXEL_BYTES + 1);

    logic [PW-1:0]        r_pos;
    logic [PW-1:0]        n_pos;
    logic [PARTIAL_W-1:0] r_partial;
    logic [PARTIAL_W-1:0] n_partial;

    logic                 accept;
    logic                 complete;
    logic [PW-1:0]        pos_eff;
    logic [BW-1:0]        pos_inc;
    logic [3:0]           bpp_wide;
    logic [3:0]           bpp_clamp;
    logic [BW-1:0]        bpp_eff;
    logic [WORD_W-1:0]    word_base;
    logic [WORD_W-1:0]    word_new;
    logic [WORD_W-1:0]    word_masked;

    // Accept a byte whenever the queue has room
    assign o_ready = i_push_ready;
    assign accept  = i_valid & o_ready;

    // Clamp bytes per pixel to 1..MAX_PIXEL_BYTES
    always_comb begin
        bpp_wide = {1'b0, i_cfg.bpp};
        if (bpp_wide == 4'd0) begin
            bpp_clamp = 4'd1;
        end else if (bpp_wide > 4'(MAX_PIXEL_BYTES)) begin
            bpp_clamp = 4'(MAX_PIXEL_BYTES);
        end else begin
            bpp_clamp = bpp_wide;
        end
        bpp_eff = BW'(bpp_clamp);
    end

    // Place the byte into its lane; frame start restarts the pixel
    always_comb begin
        pos_eff   = i_frame_start ? '0 : r_pos;
        word_base = i_frame_start ? '0 : WORD_W'(r_partial);
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            word_new[8*k +: 8]    = (pos_eff == PW'(k)) ? i_data_byte
                                                        : word_base[8*k +: 8];
            word_masked[8*k +: 8] = (BW'(k) < bpp_eff) ? word_new[8*k +: 8]
                                                        : 8'h00;
        end
        pos_inc  = BW'(pos_eff) + BW'(1);
        complete = (pos_inc >= bpp_eff);
    end

    assign o_push      = accept & complete;
    assign o_push_word = word_masked;

    // Advance or clear the byte position and partial word
    always_comb begin
        n_pos     = r_pos;
        n_partial = r_partial;
        if (accept) begin
            if (complete) begin
                n_pos     = '0;
                n_partial = '0;
            end else begin
                n_pos     = pos_inc[PW-1:0];
                n_partial = word_new[PARTIAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_partial <= '0;
        end else begin
            r_pos     <= n_pos;
            r_partial <= n_partial;
        end
    end

endmodule

@@ rtl/ppu_queue.sv @@
// ----------------------------------------------------------------------------
// ppu_queue
// Short first-in first-out queue of completed pixel words.
// ----------------------------------------------------------------------------
module ppu_queue #(
    parameter int WIDTH = 8 * ppu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output logic [WIDTH-1:0] o_pop_data,
    input  logic             i_pop
);

    logic [WIDTH-1:0]             r_mem [ppu_pkg::QUEUE_DEPTH];
    logic [ppu_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [ppu_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [ppu_pkg::QUEUE_CW-1:0] r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_push_ready = (r_count != ppu_pkg::QUEUE_CW'(ppu_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign do_push      = i_push & o_push_ready;
    assign do_pop       = i_pop & o_pop_valid;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + ppu_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + ppu_pkg::QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + ppu_pkg::QUEUE_CW'(1);
                2'b01:   r_count <= r_count - ppu_pkg::QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/ppu_back.sv @@
// ----------------------------------------------------------------------------
// ppu_back
// Field unpacker: extracts red, green and blue from a pixel word, widens
// each to eight bits and holds the result in the output register.
// ----------------------------------------------------------------------------
module ppu_back #(
    parameter int MAX_PIXEL_BYTES = ppu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppu_pkg::t_cfg                i_cfg,
    input  logic                         i_pop_valid,
    input  logic [8*MAX_PIXEL_BYTES-1:0] i_pop_data,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_red_out,
    output logic [7:0]                   o_green_out,
    output logic [7:0]                   o_blue_out
);

    localparam int WORD_W = 8 * MAX_PIXEL_BYTES;

    logic              r_valid;
    logic [7:0]        r_red;
    logic [7:0]        r_green;
    logic [7:0]        r_blue;
    logic [WORD_W-1:0] red_sh;
    logic [WORD_W-1:0] green_sh;
    logic [WORD_W-1:0] blue_sh;

    // Take a word when the output register is empty or being drained
    assign o_pop = i_pop_valid & (~r_valid | i_ready);

    // Shift each field down to bit 0; bits past the word read as zero
    assign red_sh   = i_pop_data >> i_cfg.roff;
    assign green_sh = i_pop_data >> i_cfg.goff;
    assign blue_sh  = i_pop_data >> i_cfg.boff;

    // Hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_red   <= ppu_pkg::expand_field(red_sh[7:0],   i_cfg.rsize);
            r_green <= ppu_pkg::expand_field(green_sh[7:0], i_cfg.gsize);
            r_blue  <= ppu_pkg::expand_field(blue_sh[7:0],  i_cfg.bsize);
        end
    end

    assign o_valid     = r_valid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

endmodule
